### rtl/multiply_shift_hash_conflict_check_top_defines.svh
// ----------------------------------------------------------------------------
// Multiply-shift hash checker assertion macros
// Short forms for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTIPLY_SHIFT_HASH_CONFLICT_CHECK_TOP_DEFINES_SVH
`define MULTIPLY_SHIFT_HASH_CONFLICT_CHECK_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MSH_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/msh_pkg.sv
// ----------------------------------------------------------------------------
// Multiply-shift hash checker package
// Sizes, table entry layout, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package msh_pkg;

   localparam int MAX_HASH_BITS = 12;
   localparam int TABLE_DEPTH   = 1 << MAX_HASH_BITS;
   localparam int IDX_W         = MAX_HASH_BITS;
   localparam int SLOT_W        = 12;
   localparam int DATA_W        = 64;
   localparam int HALF_W        = DATA_W / 2;
   localparam int HB_W          = 4;
   localparam int EFF_W         = $clog2(MAX_HASH_BITS + 1);
   localparam int EPOCH_W       = 8;
   localparam int CSR_IDX_W     = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_BITS  = 2'd1;

   localparam logic [HB_W-1:0] HASH_BITS_RESET = 4'd12;

   typedef enum logic [1:0] {
      ST_STORED   = 2'd0,
      ST_MATCHED  = 2'd1,
      ST_CONFLICT = 2'd2,
      ST_SKIPPED  = 2'd3
   } status_type;

   // one table word: test epoch tag plus stored value
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [DATA_W-1:0]  value;
   } entry_type;

endpackage

`default_nettype wire

### rtl/msh_mul.sv
// ----------------------------------------------------------------------------
// Multiply-shift hash checker product unit
// Low 64 bits of a 64x64 product from one shared 32x32 multiplier, 4 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module msh_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [msh_pkg::DATA_W-1:0] a,
   input  wire logic [msh_pkg::DATA_W-1:0] b,
   output logic                            done,
   output logic      [msh_pkg::DATA_W-1:0] prod
);
   import msh_pkg::*;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_SUM
   } mul_state_type;

   mul_state_type       state_ff, state_in;
   logic [DATA_W-1:0]   lo_ff, lo_in;
   logic [HALF_W-1:0]   cross_ff, cross_in;
   logic [DATA_W-1:0]   prod_ff, prod_in;
   logic                done_ff, done_in;

   logic [HALF_W-1:0]   op_a, op_b;
   logic [DATA_W-1:0]   pp;

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         MUL_LH: begin
            op_a = a[HALF_W-1:0];
            op_b = b[DATA_W-1:HALF_W];
         end
         MUL_HL: begin
            op_a = a[DATA_W-1:HALF_W];
            op_b = b[HALF_W-1:0];
         end
         default: begin
            op_a = a[HALF_W-1:0];
            op_b = b[HALF_W-1:0];
         end
      endcase
   end

   assign pp = DATA_W'(op_a) * DATA_W'(op_b);

   // step sequence; cross terms only matter in their low half
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      cross_in = cross_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MUL_IDLE: begin
            if (start) state_in = MUL_LL;
         end
         MUL_LL: begin
            lo_in    = pp;
            state_in = MUL_LH;
         end
         MUL_LH: begin
            cross_in = pp[HALF_W-1:0];
            state_in = MUL_HL;
         end
         MUL_HL: begin
            cross_in = cross_ff + pp[HALF_W-1:0];
            state_in = MUL_SUM;
         end
         MUL_SUM: begin
            prod_in  = lo_ff + {cross_ff, HALF_W'(0)};
            done_in  = 1'b1;
            state_in = MUL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      lo_ff    <= lo_in;
      cross_ff <= cross_in;
      prod_ff  <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

`default_nettype wire

### rtl/multiply_shift_hash_conflict_check_top.sv
// ----------------------------------------------------------------------------
// Multiply-shift hash conflict checker
// Hashes each key with the programmed multiplier and checks the slot table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while the item is hashed, read and checked, and the result word is strobed
// on rsp_valid for one cycle as busy falls; no new item is taken before then.
// The busy time comes from the four-step product unit (one shared 32x32
// multiplier) and the read and write-back of the slot table, a 4096-entry
// memory with one port each way. The table is not cleared per test: each
// entry carries an 8-bit epoch tag and a new test bumps the epoch. After
// reset, and on every 255th test start, busy stays high while the tags are
// swept to zero. Results cannot be held off by the receiver. Configuration
// writes are taken at any time but must only change while the block is idle.
`default_nettype none

`include "multiply_shift_hash_conflict_check_top_defines.svh"

module multiply_shift_hash_conflict_check_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // item channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [msh_pkg::DATA_W-1:0]    req_key,
   input  wire logic [msh_pkg::DATA_W-1:0]    req_value,
   input  wire logic                          req_first,
   input  wire logic                          req_last,
   // result channel
   output logic                               rsp_valid,
   output logic      [msh_pkg::SLOT_W-1:0]    rsp_slot,
   output logic      [1:0]                    rsp_status,
   output logic                               rsp_passing,
   output logic                               rsp_done_res,
   // register port
   input  wire logic                          csr_we,
   input  wire logic [msh_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [msh_pkg::DATA_W-1:0]    csr_wdata
);
   import msh_pkg::*;

   typedef enum logic [2:0] {
      S_WIPE,
      S_IDLE,
      S_MUL,
      S_READ,
      S_CHECK
   } state_type;

   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [IDX_W-1:0]   IDX_LAST    = '1;

   // registers
   logic [DATA_W-1:0]  multiplier_ff;
   logic [HB_W-1:0]    hash_bits_ff;

   // control and item state
   state_type          state_ff, state_in;
   logic               pending_ff, pending_in;
   logic [IDX_W-1:0]   wipe_ff, wipe_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               failed_ff, failed_in;
   logic               mul_start_ff, mul_start_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;

   // result word
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_passing_ff, rsp_passing_in;
   logic               rsp_done_ff, rsp_done_in;

   // table
   entry_type          mem [TABLE_DEPTH];
   entry_type          rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;

   logic               mul_done;
   logic [DATA_W-1:0]  mul_prod;
   logic [EFF_W-1:0]   eff_bits;
   logic [IDX_W-1:0]   hash_idx;
   logic               entry_hit;
   logic               entry_empty;

   msh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (key_ff),
      .b     (multiplier_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= '0;
         hash_bits_ff  <= HASH_BITS_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MULTIPLIER) multiplier_ff <= csr_wdata;
         if (csr_index == CSR_HASH_BITS)  hash_bits_ff  <= csr_wdata[HB_W-1:0];
      end
   end

   // saturate hash_bits into 1..MAX_HASH_BITS
   always_comb begin
      priority if (hash_bits_ff == '0) begin
         eff_bits = EFF_W'(1);
      end else if (32'(hash_bits_ff) > MAX_HASH_BITS) begin
         eff_bits = EFF_W'(MAX_HASH_BITS);
      end else begin
         eff_bits = EFF_W'(hash_bits_ff);
      end
   end

   // top eff_bits bits of the product
   assign hash_idx = mul_prod[DATA_W-1 -: IDX_W] >> (EFF_W'(IDX_W) - eff_bits);

   // entry lookup: stale epoch or zero value counts as empty
   assign entry_hit   = (rd_ff.tag == epoch_ff);
   assign entry_empty = !entry_hit || (rd_ff.value == '0);

   // table write select: tag sweep or store of a new value
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = '{tag: epoch_ff, value: value_ff};
      if (state_ff == S_WIPE) begin
         mem_we    = 1'b1;
         mem_waddr = wipe_ff;
         mem_wdata = '{tag: '0, value: '0};
      end else if (state_ff == S_CHECK && !failed_ff && entry_empty) begin
         mem_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[slot_ff];
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      wipe_in        = wipe_ff;
      epoch_in       = epoch_ff;
      failed_in      = failed_ff;
      mul_start_in   = 1'b0;
      key_in         = key_ff;
      value_in       = value_ff;
      last_in        = last_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = 1'b0;
      rsp_slot_in    = rsp_slot_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_passing_in = rsp_passing_ff;
      rsp_done_in    = rsp_done_ff;
      unique case (state_ff)
         S_WIPE: begin
            wipe_in = wipe_ff + IDX_W'(1);
            if (wipe_ff == IDX_LAST) begin
               epoch_in = EPOCH_FIRST;
               if (pending_ff) begin
                  pending_in   = 1'b0;
                  mul_start_in = 1'b1;
                  state_in     = S_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               key_in   = req_key;
               value_in = req_value;
               last_in  = req_last;
               if (req_first && epoch_ff == EPOCH_LAST) begin
                  // epochs used up: sweep tags, then run the item
                  failed_in  = 1'b0;
                  pending_in = 1'b1;
                  wipe_in    = '0;
                  state_in   = S_WIPE;
               end else begin
                  if (req_first) begin
                     failed_in = 1'b0;
                     epoch_in  = epoch_ff + EPOCH_W'(1);
                  end
                  mul_start_in = 1'b1;
                  state_in     = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               slot_in  = hash_idx;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (failed_ff) begin
               rsp_status_in = ST_SKIPPED;
            end else if (entry_empty) begin
               rsp_status_in = ST_STORED;
            end else if (rd_ff.value == value_ff) begin
               rsp_status_in = ST_MATCHED;
            end else begin
               rsp_status_in = ST_CONFLICT;
               failed_in     = 1'b1;
            end
            rsp_valid_in   = 1'b1;
            rsp_slot_in    = slot_ff;
            rsp_passing_in = !(failed_ff || (!entry_empty && rd_ff.value != value_ff));
            rsp_done_in    = last_ff;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         pending_ff   <= 1'b0;
         wipe_ff      <= '0;
         epoch_ff     <= '0;
         failed_ff    <= 1'b0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         wipe_ff      <= wipe_in;
         epoch_ff     <= epoch_in;
         failed_ff    <= failed_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff         <= key_in;
      value_ff       <= value_in;
      last_ff        <= last_in;
      slot_ff        <= slot_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_passing_ff <= rsp_passing_in;
      rsp_done_ff    <= rsp_done_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot     = SLOT_W'(rsp_slot_ff);
   assign rsp_status   = rsp_status_ff;
   assign rsp_passing  = rsp_passing_ff;
   assign rsp_done_res = rsp_done_ff;

   // checks
   `MSH_ASSERT_NEXT(a_check_gives_result, clock, reset,
      state_ff == S_CHECK, rsp_valid_ff, "table check did not produce a result")
   `MSH_ASSERT_IMPLIES(a_conflict_fails, clock, reset,
      rsp_valid_ff && rsp_status_ff == ST_CONFLICT, !rsp_passing_ff,
      "conflict reported as passing")
   `MSH_ASSERT_IMPLIES(a_no_store_after_fail, clock, reset,
      mem_we && state_ff == S_CHECK, !failed_ff, "table written after a failure")

endmodule

`default_nettype wire
